// ===== src/qlls_pkg.sv =====
// ---------------------------------------------------------------------------
// qlls_pkg
// Shared types and constants of the quad leg load share unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package qlls_pkg;

  // support mode of one result: all legs, or one leg lifted
  typedef logic [2:0] mode_t;

  localparam mode_t MODE_ALL   = 3'd0;
  localparam mode_t MODE_LIFT1 = 3'd1;
  localparam mode_t MODE_LIFT2 = 3'd2;
  localparam mode_t MODE_LIFT3 = 3'd3;
  localparam mode_t MODE_LIFT4 = 3'd4;

  // legs in a stance
  localparam int NUM_LEGS = 4;

  // integer bits of a share (Q4.12 at a 16-bit share)
  localparam int SHARE_INT_BITS = 4;

endpackage

// ===== src/quad_leg_load_share_unit.sv =====
// ---------------------------------------------------------------------------
// quad_leg_load_share_unit
// Static load sharing of a four-legged stance: per input item, five result
// items (all four legs, then each leg lifted in turn), shares in signed Q4.12.
// ---------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_ready   | com_x/y, foot1..4_x/y
//  out     | out_valid / out_ready | support_mode, share_leg1..4, singular,
//          |                       | saturated, last
//
//  the output port moves one result item per cycle unless out_ready stalls it;
//  each input item yields five of them, and the next input item is taken as
//  the last of the five enters the pipeline. the first result passes the
//  product stages, the divider setup and one quotient bit per divider stage.
//  rst is synchronous and clears only the valid bits and the result counter.
//  a stalled output freezes the whole pipeline; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module quad_leg_load_share_unit #(
  parameter int COORD_WIDTH = 16,
  parameter int SHARE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] com_x,
  input  logic signed [COORD_WIDTH-1:0] com_y,
  input  logic signed [COORD_WIDTH-1:0] foot1_x,
  input  logic signed [COORD_WIDTH-1:0] foot1_y,
  input  logic signed [COORD_WIDTH-1:0] foot2_x,
  input  logic signed [COORD_WIDTH-1:0] foot2_y,
  input  logic signed [COORD_WIDTH-1:0] foot3_x,
  input  logic signed [COORD_WIDTH-1:0] foot3_y,
  input  logic signed [COORD_WIDTH-1:0] foot4_x,
  input  logic signed [COORD_WIDTH-1:0] foot4_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output qlls_pkg::mode_t               support_mode,
  output logic signed [SHARE_WIDTH-1:0] share_leg1,
  output logic signed [SHARE_WIDTH-1:0] share_leg2,
  output logic signed [SHARE_WIDTH-1:0] share_leg3,
  output logic signed [SHARE_WIDTH-1:0] share_leg4,
  output logic                          singular,
  output logic                          saturated,
  output logic                          last
);

  import qlls_pkg::*;

  // widths
  localparam int CW   = COORD_WIDTH;
  localparam int SW   = SHARE_WIDTH;
  localparam int FRAC = SW - SHARE_INT_BITS;
  localparam int UW   = CW + 1;          // foot offset
  localparam int SUMW = UW + 2;          // sum of four offsets
  localparam int PRW  = 2 * UW;          // offset product
  localparam int QW   = PRW + 2;         // sum of four products
  localparam int CRW  = PRW + 1;         // cross term
  localparam int KNW  = CRW + 1;         // three-leg numerator
  localparam int KDW  = CRW + 3;         // three-leg divisor
  localparam int HQ   = QW / 2;          // low half of a moment
  localparam int PLW  = QW + HQ + 1;
  localparam int PHW  = 2 * QW - HQ;
  localparam int PW   = 2 * QW + 1;      // P
  localparam int QRW  = SUMW + QW + 1;   // Q and R
  localparam int HR   = QRW / 2;         // low half of Q and R
  localparam int XLW  = SUMW + HR + 1;
  localparam int XHW  = SUMW + QRW - HR;
  localparam int ULW  = UW + HR + 1;
  localparam int UHW  = UW + QRW - HR;
  localparam int DW   = 2 * QW + 6;      // numerators and divisors
  localparam int AW   = DW + FRAC;       // scaled numerator magnitude
  localparam int RW   = DW + 1;          // divider remainder

  logic advance;

  // ---------------------------------------------------------------------
  // input hold register and result counter
  // ---------------------------------------------------------------------
  logic                 hold_vld;
  mode_t                cnt;
  logic signed [CW-1:0] h_cx, h_cy;
  logic signed [CW-1:0] h_fx [NUM_LEGS];
  logic signed [CW-1:0] h_fy [NUM_LEGS];

  assign advance  = !out_valid || out_ready;
  assign in_ready = !hold_vld || (cnt == MODE_LIFT4 && advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= 1'b0;
      cnt      <= MODE_ALL;
    end else if (in_valid && in_ready) begin
      hold_vld <= 1'b1;
      cnt      <= MODE_ALL;
    end else if (advance && hold_vld) begin
      if (cnt == MODE_LIFT4) begin
        hold_vld <= 1'b0;
      end else begin
        cnt <= mode_t'(cnt + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      h_cx    <= com_x;
      h_cy    <= com_y;
      h_fx[0] <= foot1_x;
      h_fy[0] <= foot1_y;
      h_fx[1] <= foot2_x;
      h_fy[1] <= foot2_y;
      h_fx[2] <= foot3_x;
      h_fy[2] <= foot3_y;
      h_fx[3] <= foot4_x;
      h_fy[3] <= foot4_y;
    end
  end

  // ---------------------------------------------------------------------
  // stage registers
  // ---------------------------------------------------------------------
  logic s1_vld, s2_vld, s3_vld, s4_vld, s5_vld, s6_vld, s7_vld, s8_vld, s9_vld;
  mode_t s1_mode, s2_mode, s3_mode, s4_mode, s5_mode, s6_mode, s7_mode;
  mode_t s8_mode, s9_mode;

  logic signed [UW-1:0]   s1_u [NUM_LEGS], s1_v [NUM_LEGS];
  logic signed [UW-1:0]   s2_u [NUM_LEGS], s2_v [NUM_LEGS];
  logic signed [UW-1:0]   s3_u [NUM_LEGS], s3_v [NUM_LEGS];
  logic signed [UW-1:0]   s4_u [NUM_LEGS], s4_v [NUM_LEGS];
  logic signed [UW-1:0]   s5_u [NUM_LEGS], s5_v [NUM_LEGS];

  logic signed [PRW-1:0]  s2_m [NUM_LEGS][NUM_LEGS];
  logic signed [PRW-1:0]  s2_uu [NUM_LEGS], s2_vv [NUM_LEGS];
  logic signed [SUMW-1:0] s2_xi, s2_eta, s3_xi, s3_eta, s4_xi, s4_eta, s5_xi, s5_eta;

  logic signed [QW-1:0]   s3_xi2, s3_eta2, s3_xieta;
  logic signed [CRW-1:0]  s3_c [NUM_LEGS][NUM_LEGS];

  logic signed [KNW-1:0]  kn_next [NUM_LEGS];
  logic signed [KNW-1:0]  s4_kn [NUM_LEGS], s5_kn [NUM_LEGS], s6_kn [NUM_LEGS];
  logic signed [KNW-1:0]  s7_kn [NUM_LEGS];
  logic signed [PLW-1:0]  s4_pa_lo, s4_pb_lo;
  logic signed [PHW-1:0]  s4_pa_hi, s4_pb_hi;
  logic signed [SUMW+QW-1:0] s4_q1, s4_q2, s4_r1, s4_r2;

  logic signed [KDW-1:0]  s5_kd, s6_kd, s7_kd;
  logic signed [PW-1:0]   s5_p, s6_p, s7_p;
  logic signed [QRW-1:0]  s5_q, s5_r;

  logic signed [XLW-1:0]  s6_xq_lo, s6_er_lo;
  logic signed [XHW-1:0]  s6_xq_hi, s6_er_hi;
  logic signed [ULW-1:0]  s6_qu_lo [NUM_LEGS], s6_rv_lo [NUM_LEGS];
  logic signed [UHW-1:0]  s6_qu_hi [NUM_LEGS], s6_rv_hi [NUM_LEGS];

  logic signed [DW-1:0]   s7_xq, s7_er;
  logic signed [DW-1:0]   s7_qu [NUM_LEGS], s7_rv [NUM_LEGS];

  logic signed [DW-1:0]   s8_num [NUM_LEGS];
  logic signed [DW-1:0]   s8_den;

  logic [DW-1:0]          s9_an [NUM_LEGS];
  logic [DW-1:0]          s9_ad;
  logic                   s9_neg [NUM_LEGS];
  logic                   s9_dz;

  // divider stages: index 0 holds the initial remainder, index k quotient bit k
  logic                   dv_vld  [0:SW];
  mode_t                  dv_mode [0:SW];
  logic [RW-1:0]          dv_rem  [0:SW][NUM_LEGS];
  logic [SW-1:0]          dv_low  [0:SW][NUM_LEGS];
  logic [SW-1:0]          dv_q    [0:SW][NUM_LEGS];
  logic                   dv_ovf  [0:SW][NUM_LEGS];
  logic                   dv_neg  [0:SW][NUM_LEGS];
  logic [DW-1:0]          dv_ad   [0:SW];
  logic                   dv_dz   [0:SW];

  logic [AW-1:0]          dv0_full [NUM_LEGS];
  logic [RW-1:0]          step_sh  [1:SW][NUM_LEGS];
  logic                   step_ge  [1:SW][NUM_LEGS];
  logic [RW-1:0]          step_rem_next [1:SW][NUM_LEGS];
  logic [SW-1:0]          step_q_next   [1:SW][NUM_LEGS];

  logic signed [SW-1:0]   fin_val  [NUM_LEGS];
  logic                   fin_over [NUM_LEGS];
  logic [SW-1:0]          lim_pos, lim_neg;

  // valid bits travel with each result item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      s3_vld    <= 1'b0;
      s4_vld    <= 1'b0;
      s5_vld    <= 1'b0;
      s6_vld    <= 1'b0;
      s7_vld    <= 1'b0;
      s8_vld    <= 1'b0;
      s9_vld    <= 1'b0;
      for (int k = 0; k <= SW; k++) dv_vld[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_vld    <= hold_vld;
      s2_vld    <= s1_vld;
      s3_vld    <= s2_vld;
      s4_vld    <= s3_vld;
      s5_vld    <= s4_vld;
      s6_vld    <= s5_vld;
      s7_vld    <= s6_vld;
      s8_vld    <= s7_vld;
      s9_vld    <= s8_vld;
      dv_vld[0] <= s9_vld;
      for (int k = 1; k <= SW; k++) dv_vld[k] <= dv_vld[k-1];
      out_valid <= dv_vld[SW];
    end
  end

  // stages 1 to 3: offsets, products, moments and cross terms
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_mode <= cnt;
      for (int i = 0; i < NUM_LEGS; i++) begin
        s1_u[i] <= UW'(h_fx[i]) - UW'(h_cx);
        s1_v[i] <= UW'(h_fy[i]) - UW'(h_cy);
      end

      s2_mode <= s1_mode;
      for (int p = 0; p < NUM_LEGS; p++) begin
        for (int q = 0; q < NUM_LEGS; q++) s2_m[p][q] <= s1_u[p] * s1_v[q];
        s2_uu[p] <= s1_u[p] * s1_u[p];
        s2_vv[p] <= s1_v[p] * s1_v[p];
        s2_u[p]  <= s1_u[p];
        s2_v[p]  <= s1_v[p];
      end
      s2_xi  <= SUMW'(s1_u[0]) + SUMW'(s1_u[1]) + SUMW'(s1_u[2]) + SUMW'(s1_u[3]);
      s2_eta <= SUMW'(s1_v[0]) + SUMW'(s1_v[1]) + SUMW'(s1_v[2]) + SUMW'(s1_v[3]);

      s3_mode  <= s2_mode;
      s3_xi2   <= QW'(s2_uu[0]) + QW'(s2_uu[1]) + QW'(s2_uu[2]) + QW'(s2_uu[3]);
      s3_eta2  <= QW'(s2_vv[0]) + QW'(s2_vv[1]) + QW'(s2_vv[2]) + QW'(s2_vv[3]);
      s3_xieta <= QW'(s2_m[0][0]) + QW'(s2_m[1][1]) + QW'(s2_m[2][2])
                  + QW'(s2_m[3][3]);
      for (int p = 0; p < NUM_LEGS; p++) begin
        for (int q = 0; q < NUM_LEGS; q++) begin
          s3_c[p][q] <= CRW'(s2_m[p][q]) - CRW'(s2_m[q][p]);
        end
        s3_u[p] <= s2_u[p];
        s3_v[p] <= s2_v[p];
      end
      s3_xi  <= s2_xi;
      s3_eta <= s2_eta;
    end
  end

  // three-leg numerators: remaining legs a < b < c take c(b,c), c(c,a), c(a,b)
  always_comb begin
    for (int i = 0; i < NUM_LEGS; i++) kn_next[i] = '0;
    case (s3_mode)
      MODE_LIFT1: begin
        kn_next[1] = KNW'(s3_c[2][3]);
        kn_next[2] = -KNW'(s3_c[1][3]);
        kn_next[3] = KNW'(s3_c[1][2]);
      end
      MODE_LIFT2: begin
        kn_next[0] = KNW'(s3_c[2][3]);
        kn_next[2] = -KNW'(s3_c[0][3]);
        kn_next[3] = KNW'(s3_c[0][2]);
      end
      MODE_LIFT3: begin
        kn_next[0] = KNW'(s3_c[1][3]);
        kn_next[1] = -KNW'(s3_c[0][3]);
        kn_next[3] = KNW'(s3_c[0][1]);
      end
      MODE_LIFT4: begin
        kn_next[0] = KNW'(s3_c[1][2]);
        kn_next[1] = -KNW'(s3_c[0][2]);
        kn_next[2] = KNW'(s3_c[0][1]);
      end
      default: begin
      end
    endcase
  end

  // stages 4 and 5: split moment products, then P, Q, R
  always_ff @(posedge clk) begin
    if (advance) begin
      s4_mode  <= s3_mode;
      s4_kn    <= kn_next;
      s4_pa_lo <= s3_xi2 * $signed({1'b0, s3_eta2[HQ-1:0]});
      s4_pa_hi <= s3_xi2 * $signed(s3_eta2[QW-1:HQ]);
      s4_pb_lo <= s3_xieta * $signed({1'b0, s3_xieta[HQ-1:0]});
      s4_pb_hi <= s3_xieta * $signed(s3_xieta[QW-1:HQ]);
      s4_q1    <= s3_xi * s3_eta2;
      s4_q2    <= s3_xieta * s3_eta;
      s4_r1    <= s3_xi * s3_xieta;
      s4_r2    <= s3_xi2 * s3_eta;
      s4_xi    <= s3_xi;
      s4_eta   <= s3_eta;
      s4_u     <= s3_u;
      s4_v     <= s3_v;

      s5_mode <= s4_mode;
      s5_kn   <= s4_kn;
      s5_kd   <= KDW'(s4_kn[0]) + KDW'(s4_kn[1]) + KDW'(s4_kn[2]) + KDW'(s4_kn[3]);
      s5_p    <= (PW'(s4_pa_hi) <<< HQ) + PW'(s4_pa_lo)
                 - ((PW'(s4_pb_hi) <<< HQ) + PW'(s4_pb_lo));
      s5_q    <= QRW'(s4_q1) - QRW'(s4_q2);
      s5_r    <= QRW'(s4_r1) - QRW'(s4_r2);
      s5_xi   <= s4_xi;
      s5_eta  <= s4_eta;
      s5_u    <= s4_u;
      s5_v    <= s4_v;
    end
  end

  // stages 6 to 8: split products with Q and R, recombine, numerators
  always_ff @(posedge clk) begin
    if (advance) begin
      s6_mode  <= s5_mode;
      s6_kn    <= s5_kn;
      s6_kd    <= s5_kd;
      s6_p     <= s5_p;
      s6_xq_lo <= s5_xi * $signed({1'b0, s5_q[HR-1:0]});
      s6_xq_hi <= s5_xi * $signed(s5_q[QRW-1:HR]);
      s6_er_lo <= s5_eta * $signed({1'b0, s5_r[HR-1:0]});
      s6_er_hi <= s5_eta * $signed(s5_r[QRW-1:HR]);
      for (int i = 0; i < NUM_LEGS; i++) begin
        s6_qu_lo[i] <= s5_u[i] * $signed({1'b0, s5_q[HR-1:0]});
        s6_qu_hi[i] <= s5_u[i] * $signed(s5_q[QRW-1:HR]);
        s6_rv_lo[i] <= s5_v[i] * $signed({1'b0, s5_r[HR-1:0]});
        s6_rv_hi[i] <= s5_v[i] * $signed(s5_r[QRW-1:HR]);
      end

      s7_mode <= s6_mode;
      s7_kn   <= s6_kn;
      s7_kd   <= s6_kd;
      s7_p    <= s6_p;
      s7_xq   <= (DW'(s6_xq_hi) <<< HR) + DW'(s6_xq_lo);
      s7_er   <= (DW'(s6_er_hi) <<< HR) + DW'(s6_er_lo);
      for (int i = 0; i < NUM_LEGS; i++) begin
        s7_qu[i] <= (DW'(s6_qu_hi[i]) <<< HR) + DW'(s6_qu_lo[i]);
        s7_rv[i] <= (DW'(s6_rv_hi[i]) <<< HR) + DW'(s6_rv_lo[i]);
      end

      s8_mode <= s7_mode;
      if (s7_mode == MODE_ALL) begin
        s8_den <= (DW'(s7_p) <<< 2) - s7_xq + s7_er;
        for (int i = 0; i < NUM_LEGS; i++) begin
          s8_num[i] <= DW'(s7_p) - s7_qu[i] + s7_rv[i];
        end
      end else begin
        s8_den <= DW'(s7_kd);
        for (int i = 0; i < NUM_LEGS; i++) s8_num[i] <= DW'(s7_kn[i]);
      end
    end
  end

  // divider setup: magnitudes, signs, scaled numerator and range check
  always_comb begin
    for (int i = 0; i < NUM_LEGS; i++) dv0_full[i] = {s9_an[i], {FRAC{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s9_mode <= s8_mode;
      s9_ad   <= s8_den[DW-1] ? -s8_den : s8_den;
      s9_dz   <= (s8_den == '0);
      for (int i = 0; i < NUM_LEGS; i++) begin
        s9_an[i]  <= s8_num[i][DW-1] ? -s8_num[i] : s8_num[i];
        s9_neg[i] <= s8_num[i][DW-1] ^ s8_den[DW-1];
      end

      dv_mode[0] <= s9_mode;
      dv_ad[0]   <= s9_ad;
      dv_dz[0]   <= s9_dz;
      for (int i = 0; i < NUM_LEGS; i++) begin
        dv_rem[0][i] <= RW'(dv0_full[i][AW-1:SW]);
        dv_ovf[0][i] <= RW'(dv0_full[i][AW-1:SW]) >= RW'(s9_ad);
        dv_low[0][i] <= dv0_full[i][SW-1:0];
        dv_q[0][i]   <= '0;
        dv_neg[0][i] <= s9_neg[i];
      end
    end
  end

  // restoring divider: one quotient bit per stage in each of four lanes
  always_comb begin
    for (int k = 1; k <= SW; k++) begin
      for (int i = 0; i < NUM_LEGS; i++) begin
        step_sh[k][i] = {dv_rem[k-1][i][RW-2:0], dv_low[k-1][i][SW-1]};
        step_ge[k][i] = step_sh[k][i] >= RW'(dv_ad[k-1]);
        step_rem_next[k][i] = step_ge[k][i] ? step_sh[k][i] - RW'(dv_ad[k-1])
                                            : step_sh[k][i];
        step_q_next[k][i] = {dv_q[k-1][i][SW-2:0], step_ge[k][i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 1; k <= SW; k++) begin
        dv_mode[k] <= dv_mode[k-1];
        dv_ad[k]   <= dv_ad[k-1];
        dv_dz[k]   <= dv_dz[k-1];
        for (int i = 0; i < NUM_LEGS; i++) begin
          dv_rem[k][i] <= step_rem_next[k][i];
          dv_q[k][i]   <= step_q_next[k][i];
          dv_low[k][i] <= dv_low[k-1][i] << 1;
          dv_ovf[k][i] <= dv_ovf[k-1][i];
          dv_neg[k][i] <= dv_neg[k-1][i];
        end
      end
    end
  end

  // sign, saturation and the zero divisor case
  assign lim_pos = {1'b0, {(SW-1){1'b1}}};
  assign lim_neg = {1'b1, {(SW-1){1'b0}}};

  always_comb begin
    for (int i = 0; i < NUM_LEGS; i++) begin
      if (dv_dz[SW]) begin
        fin_over[i] = 1'b0;
        fin_val[i]  = '0;
      end else if (dv_neg[SW][i] && (dv_ovf[SW][i] || dv_q[SW][i] != '0)) begin
        fin_over[i] = dv_ovf[SW][i] || (dv_q[SW][i] > lim_neg);
        fin_val[i]  = fin_over[i] ? lim_neg : -dv_q[SW][i];
      end else begin
        fin_over[i] = dv_ovf[SW][i] || (dv_q[SW][i] > lim_pos);
        fin_val[i]  = fin_over[i] ? lim_pos : dv_q[SW][i];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (advance) begin
      support_mode <= dv_mode[SW];
      share_leg1   <= fin_val[0];
      share_leg2   <= fin_val[1];
      share_leg3   <= fin_val[2];
      share_leg4   <= fin_val[3];
      singular     <= dv_dz[SW];
      saturated    <= fin_over[0] || fin_over[1] || fin_over[2] || fin_over[3];
      last         <= (dv_mode[SW] == MODE_LIFT4);
    end
  end

  // checks
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    hold_vld && !advance |=> hold_vld && $stable(cnt))
    else $error("result counter moved during a stall");

  a_accept_at_end: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && hold_vld |-> cnt == MODE_LIFT4)
    else $error("new item taken before all results of the last one issued");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> share_leg1 == '0 && share_leg2 == '0
      && share_leg3 == '0 && share_leg4 == '0 && !saturated)
    else $error("singular result carries nonzero shares");

  a_last_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> last == (support_mode == MODE_LIFT4))
    else $error("last flag does not match support mode");

  a_lifted_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (support_mode != MODE_LIFT1 || share_leg1 == '0)
      && (support_mode != MODE_LIFT2 || share_leg2 == '0)
      && (support_mode != MODE_LIFT3 || share_leg3 == '0)
      && (support_mode != MODE_LIFT4 || share_leg4 == '0))
    else $error("lifted leg has a nonzero share");

endmodule
